// ----- rtl/core/bis_pkg.sv -----
package bis_pkg;

    localparam int VALUE_W     = 64;
    localparam int OPCODE_W    = 3;
    localparam int BYTE_W      = 8;
    localparam int GROUP_W     = 7;
    localparam int NBYTES_W    = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;

    typedef enum logic [OPCODE_W-1:0] {
        OP_U8     = 3'd0,
        OP_U16    = 3'd1,
        OP_U32    = 3'd2,
        OP_U64    = 3'd3,
        OP_VAR32  = 3'd4,
        OP_VAR64  = 3'd5
    } opcode_t;

    // One classified item. Fixed formats arrive left aligned so that the
    // first byte to send sits in the top byte of data.
    typedef struct packed {
        logic                varint;
        logic [NBYTES_W-1:0] nbytes;
        logic [VALUE_W-1:0]  data;
    } bis_entry_t;

endpackage

// ----- rtl/core/bis_if.sv -----
interface bis_in_if import bis_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [OPCODE_W-1:0] opcode;
    logic                zigzag;

    modport source (output valid, value, opcode, zigzag, input ready);
    modport sink   (input valid, value, opcode, zigzag, output ready);
endinterface

interface bis_out_if import bis_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// ----- rtl/core/binary_integer_serializer.sv -----
// Channel   Dir   Payload                         Transfer
// item      in    value[63:0] opcode[2:0] zigzag  valid && ready
// stream    out   out_byte[7:0] last              valid && ready
//
// Each item gives one byte per cycle while stream is ready: 1, 2, 4 or 8 bytes
// for the fixed formats, 1 to 5 for varint32 and 1 to 10 for varint64, set by
// a back-end counter or shift register. Opcodes 6 and 7 are taken and give no bytes.
// A front register and a small queue let items arrive while a run streams.
// Reset (rst_n low) empties the queue and ends any run in flight.
// A stall on stream holds the current byte; item backs up once the queue fills.
module binary_integer_serializer import bis_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    bis_in_if.sink    item,
    bis_out_if.source stream
);

    logic       f_valid;
    logic       f_ready;
    bis_entry_t f_entry;
    logic       b_valid;
    logic       b_ready;
    bis_entry_t b_entry;

    bis_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_entry (f_entry)
    );

    bis_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_entry (f_entry),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_entry  (b_entry)
    );

    bis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_entry (b_entry),
        .stream    (stream)
    );

endmodule

// ----- rtl/core/bis_front.sv -----
module bis_front import bis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bis_in_if.sink     item,
    output logic       push_valid,
    input  logic       push_ready,
    output bis_entry_t push_entry
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    bis_entry_t hold_entry_reg;
    bis_entry_t hold_entry_next;
    logic       accept;
    logic       op_known;
    logic [31:0] low_word;
    logic [31:0] zz_word;
    logic [VALUE_W-1:0] zz_value;

    assign item.ready = !hold_valid_reg || push_ready;
    assign accept     = item.valid && item.ready;
    assign push_valid = hold_valid_reg;
    assign push_entry = hold_entry_reg;

    assign low_word = item.value[31:0];
    assign zz_word  = {low_word[30:0], 1'b0} ^ {32{low_word[31]}};
    assign zz_value = {item.value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{item.value[VALUE_W-1]}};

    always_comb
    begin
        hold_entry_next        = hold_entry_reg;
        hold_entry_next.varint = 1'b0;
        op_known               = 1'b1;
        case (item.opcode)
            OP_U8:
            begin
                hold_entry_next.nbytes = NBYTES_W'(1);
                hold_entry_next.data   = {item.value[7:0], 56'd0};
            end
            OP_U16:
            begin
                hold_entry_next.nbytes = NBYTES_W'(2);
                hold_entry_next.data   = {item.value[15:0], 48'd0};
            end
            OP_U32:
            begin
                hold_entry_next.nbytes = NBYTES_W'(4);
                hold_entry_next.data   = {low_word, 32'd0};
            end
            OP_U64:
            begin
                hold_entry_next.nbytes = NBYTES_W'(8);
                hold_entry_next.data   = item.value;
            end
            OP_VAR32:
            begin
                hold_entry_next.varint = 1'b1;
                hold_entry_next.nbytes = '0;
                hold_entry_next.data   = {32'd0, item.zigzag ? zz_word : low_word};
            end
            OP_VAR64:
            begin
                hold_entry_next.varint = 1'b1;
                hold_entry_next.nbytes = '0;
                hold_entry_next.data   = item.zigzag ? zz_value : item.value;
            end
            default:
            begin
                op_known = 1'b0;
            end
        endcase
    end

    // Unknown opcodes are taken and dropped here; they produce no bytes.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = op_known;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_entry_reg <= hold_entry_next;
        end
    end

    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !hold_entry_reg.varint |->
            (hold_entry_reg.nbytes == NBYTES_W'(1) || hold_entry_reg.nbytes == NBYTES_W'(2) ||
             hold_entry_reg.nbytes == NBYTES_W'(4) || hold_entry_reg.nbytes == NBYTES_W'(8)))
        else $error("fixed entry with a bad byte count");

endmodule

// ----- rtl/core/bis_queue.sv -----
module bis_queue import bis_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  bis_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output bis_entry_t pop_entry
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bis_entry_t     slot_reg [DEPTH];
    logic [IW-1:0]  wr_ptr_reg;
    logic [IW-1:0]  wr_ptr_next;
    logic [IW-1:0]  rd_ptr_reg;
    logic [IW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push;
    logic           pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + IW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + IW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// ----- rtl/core/bis_back.sv -----
module bis_back import bis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  bis_entry_t pop_entry,
    bis_out_if.source  stream
);

    logic                busy_reg;
    logic                busy_next;
    logic                varint_reg;
    logic [NBYTES_W-1:0] cnt_reg;
    logic [NBYTES_W-1:0] cnt_next;
    logic [VALUE_W-1:0]  sr_reg;
    logic [VALUE_W-1:0]  sr_next;
    logic                last_now;
    logic                more_groups;
    logic                xfer;
    logic                load;

    // A varint continues while any bit above the current group is set.
    assign more_groups = sr_reg[VALUE_W-1:GROUP_W] != '0;
    assign last_now    = varint_reg ? !more_groups : (cnt_reg == NBYTES_W'(1));

    assign stream.valid    = busy_reg;
    assign stream.last     = last_now;
    assign stream.out_byte = varint_reg
        ? ((sr_reg[BYTE_W-1:0] & GROUP_MASK) | (more_groups ? CONT_BIT : '0))
        : sr_reg[VALUE_W-1 -: BYTE_W];

    assign xfer      = stream.valid && stream.ready;
    assign pop_ready = !busy_reg || (xfer && last_now);
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        busy_next = busy_reg;
        sr_next   = sr_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            sr_next   = pop_entry.data;
            cnt_next  = pop_entry.nbytes;
        end
        else if (xfer)
        begin
            busy_next = !last_now;
            sr_next   = varint_reg ? (sr_reg >> GROUP_W) : (sr_reg << BYTE_W);
            cnt_next  = cnt_reg - NBYTES_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg  <= sr_next;
        cnt_reg <= cnt_next;
        if (load)
        begin
            varint_reg <= pop_entry.varint;
        end
    end

    a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && varint_reg |-> (stream.out_byte[BYTE_W-1] == !stream.last))
        else $error("varint continuation bit disagrees with last");

    a_fixed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !varint_reg |-> cnt_reg != '0)
        else $error("fixed run with no bytes left");

    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !last_now |=> busy_reg)
        else $error("run ended before its last byte");

endmodule

// ----- dv/testbench.sv -----
module testbench;
    import bis_pkg::*;

    localparam int ITEM_COUNT   = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int MAX_BYTES    = 10;

    // Opcodes outside the enum; the block takes them and sends nothing.
    localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    typedef struct {
        logic [VALUE_W-1:0]          value;
        logic [OPCODE_W-1:0]         opcode;
        logic                        zigzag;
        bit                          typed;
        int                          nbytes;
        logic [BYTE_W*MAX_BYTES-1:0] bytes;
    } vector_t;

    logic clk = 1'b0;
    logic rst_n;

    bis_in_if  item_if ();
    bis_out_if stream_if ();

    binary_integer_serializer i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .stream (stream_if)
    );

    beat_t   expected_bytes[$];
    vector_t directed_vectors[$];
    int      mismatches  = 0;
    int      beats_seen  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pushes the bytes one item must produce, in the order they leave the block.
    function automatic void encode_value(input logic [VALUE_W-1:0] value,
                                         input logic [OPCODE_W-1:0] opcode,
                                         input logic zigzag);
        logic [VALUE_W-1:0] v;
        logic [BYTE_W-1:0]  grp;
        int                 nbytes;
        bit                 varint;
        bit                 done;
        nbytes = 0;
        varint = 1'b0;
        v      = value;
        case (opcode)
            OP_U8:    nbytes = 1;
            OP_U16:   nbytes = 2;
            OP_U32:   nbytes = 4;
            OP_U64:   nbytes = 8;
            OP_VAR32:
            begin
                varint = 1'b1;
                v = {32'b0, value[31:0]};
                if (zigzag)
                    v = {32'b0, {value[30:0], 1'b0} ^ {32{value[31]}}};
            end
            OP_VAR64:
            begin
                varint = 1'b1;
                if (zigzag)
                    v = {value[62:0], 1'b0} ^ {64{value[63]}};
            end
            default: nbytes = 0;
        endcase
        for (int i = nbytes - 1; i >= 0; i--)
            expected_bytes.push_back({value[8*i +: 8], i == 0});
        if (varint)
        begin
            done = 1'b0;
            for (int n = 0; n < MAX_BYTES && !done; n++)
            begin
                grp = v[BYTE_W-1:0] & GROUP_MASK;
                v   = v >> GROUP_W;
                if (v != 0 && n < MAX_BYTES - 1)
                    expected_bytes.push_back({grp | CONT_BIT, 1'b0});
                else
                begin
                    expected_bytes.push_back({grp, 1'b1});
                    done = 1'b1;
                end
            end
        end
    endfunction

    task automatic add_vector(input logic [VALUE_W-1:0] value,
                              input logic [OPCODE_W-1:0] opcode,
                              input logic zigzag,
                              input bit typed,
                              input int nbytes,
                              input logic [BYTE_W*MAX_BYTES-1:0] bytes);
        vector_t vec;
        vec.value  = value;
        vec.opcode = opcode;
        vec.zigzag = zigzag;
        vec.typed  = typed;
        vec.nbytes = nbytes;
        vec.bytes  = bytes;
        directed_vectors.push_back(vec);
    endtask

    // Offers one item in the current burst and records its bytes once it is taken.
    task automatic send_item(input vector_t vec);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                item_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        item_if.valid  = 1'b1;
        item_if.value  = vec.value;
        item_if.opcode = vec.opcode;
        item_if.zigzag = vec.zigzag;
        do
            @(posedge clk);
        while (!item_if.ready);
        burst_left--;
        if (vec.typed)
        begin
            for (int i = 0; i < vec.nbytes; i++)
                expected_bytes.push_back({vec.bytes[8*(vec.nbytes-1-i) +: 8],
                                          i == vec.nbytes - 1});
        end
        else
            encode_value(vec.value, vec.opcode, vec.zigzag);
    endtask

    task automatic await_drain();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        vector_t vec;
        int      sent;
        int      shape;
        bit      paused;
        item_if.valid  = 1'b0;
        item_if.value  = '0;
        item_if.opcode = '0;
        item_if.zigzag = 1'b0;
        rst_n          = 1'b0;

        add_vector(64'hFFFF_FFFF_FFFF_FFA5, OP_U8,     1'b0, 1, 1, 80'hA5);
        add_vector(64'h0,                   OP_U8,     1'b0, 1, 1, 80'h00);
        add_vector(64'h1234_5678_9ABC_DEF0, OP_U16,    1'b0, 1, 2, 80'hDEF0);
        add_vector(64'h1234_5678_9ABC_DEF0, OP_U32,    1'b0, 1, 4, 80'h9ABC_DEF0);
        add_vector(64'h1234_5678_9ABC_DEF0, OP_U64,    1'b0, 1, 8,
                   80'h1234_5678_9ABC_DEF0);
        add_vector(64'hFFFF_FFFF_FFFF_FFFF, OP_U64,    1'b1, 1, 8,
                   80'hFFFF_FFFF_FFFF_FFFF);
        add_vector(64'h0000_0000_0000_8001, OP_U16,    1'b1, 1, 2, 80'h8001);
        add_vector(64'h0,                   OP_VAR32,  1'b0, 1, 1, 80'h00);
        add_vector(64'h0,                   OP_VAR64,  1'b0, 1, 1, 80'h00);
        add_vector(64'h0,                   OP_VAR64,  1'b1, 1, 1, 80'h00);
        add_vector(64'h7F,                  OP_VAR32,  1'b0, 1, 1, 80'h7F);
        add_vector(64'h80,                  OP_VAR32,  1'b0, 1, 2, 80'h8001);
        add_vector(64'hFFFF_FFFF_FFFF_FFFF, OP_VAR32,  1'b0, 1, 5, 80'hFF_FFFF_FF0F);
        add_vector(64'hFFFF_FFFF_FFFF_FFFF, OP_VAR64,  1'b0, 1, 10,
                   80'hFFFF_FFFF_FFFF_FFFF_FF01);
        add_vector(64'h0000_0000_FFFF_FFFF, OP_VAR32,  1'b1, 1, 1, 80'h01);
        add_vector(64'h1,                   OP_VAR32,  1'b1, 1, 1, 80'h02);
        add_vector(64'h0000_0000_7FFF_FFFF, OP_VAR32,  1'b1, 1, 5, 80'hFE_FFFF_FF0F);
        add_vector(64'hFFFF_FFFF_FFFF_FFFF, OP_VAR64,  1'b1, 1, 1, 80'h01);
        add_vector(64'h8000_0000_0000_0000, OP_VAR64,  1'b1, 1, 10,
                   80'hFFFF_FFFF_FFFF_FFFF_FF01);
        add_vector(64'hFFFF_FFFF_FFFF_FFFF, OP_SPARE6, 1'b0, 1, 0, 80'h0);
        add_vector(64'h1234_5678_9ABC_DEF0, OP_SPARE7, 1'b1, 1, 0, 80'h0);
        add_vector(64'h8000_0000_0000_0000, OP_VAR64,  1'b0, 0, 0, 80'h0);
        add_vector(64'h0000_0000_8000_0000, OP_VAR32,  1'b1, 0, 0, 80'h0);
        add_vector(64'h0123_4567_89AB_CDEF, OP_VAR64,  1'b1, 0, 0, 80'h0);
        add_vector(64'hFFFF_FFFF_0000_3FFF, OP_VAR32,  1'b0, 0, 0, 80'h0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_vectors[i])
            send_item(directed_vectors[i]);
        await_drain();

        sent   = 0;
        paused = 1'b0;
        while (sent < ITEM_COUNT)
        begin
            vec.typed  = 1'b0;
            vec.nbytes = 0;
            vec.bytes  = '0;
            vec.value  = {$urandom(), $urandom()};
            shape      = $urandom_range(0, 9);
            // Shorter values spread the varint lengths; inverted ones give
            // small negative numbers for the zigzag mapping.
            if (shape >= 4 && shape <= 6)
                vec.value = vec.value >> $urandom_range(0, 63);
            else if (shape == 7)
                vec.value = ~(vec.value >> $urandom_range(1, 63));
            else if (shape == 8)
                vec.value = (shape == $urandom_range(8, 9)) ? 64'h0 :
                            64'h1 << $urandom_range(0, 63);
            if ($urandom_range(0, 19) == 0)
                vec.opcode = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
            else
                vec.opcode = OPCODE_W'($urandom_range(0, 5));
            vec.zigzag = 1'($urandom_range(0, 1));
            send_item(vec);
            if (vec.opcode != OP_SPARE6 && vec.opcode != OP_SPARE7)
                sent++;
            if (!paused && sent == ITEM_COUNT / 2)
            begin
                paused = 1'b1;
                await_drain();
            end
        end

        await_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // The receiver alternates free-running, patchy and mostly stalled
    // stretches, and holds off once for a long time so the block backs up.
    initial
    begin
        int  stretch_left;
        int  mode;
        int  hold_left;
        bit  held;
        stream_if.ready = 1'b0;
        stretch_left    = 0;
        mode            = 0;
        hold_left       = 0;
        held            = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && beats_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (stretch_left == 0)
            begin
                mode         = $urandom_range(0, 2);
                stretch_left = $urandom_range(1, 40);
            end
            stretch_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                stream_if.ready = 1'b0;
            end
            else if (mode == 0)
                stream_if.ready = 1'b1;
            else if (mode == 1)
                stream_if.ready = 1'($urandom_range(0, 1));
            else
                stream_if.ready = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && stream_if.valid && stream_if.ready)
        begin
            beats_seen++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transfer, expected nothing, got data %h last %b",
                         $time, stream_if.out_byte, stream_if.last);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (stream_if.out_byte !== want.data || stream_if.last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: expected data %h last %b, got data %h last %b",
                             $time, want.data, want.last,
                             stream_if.out_byte, stream_if.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes outstanding",
                     $time, expected_bytes.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
